// ===== design/sbq_pkg.sv =====
package sbq_pkg;

  // fixed-point formats
  localparam int unsigned COEF_FRAC_BITS = 30;
  localparam int unsigned HIST_W         = 48;
  localparam int unsigned WORK_FRAC      = 8;
  localparam int unsigned WORK_W         = 26;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned VOL_W          = 7;
  localparam int unsigned PROD_W         = COEF_W + WORK_W;
  localparam int unsigned ACC_W          = PROD_W + 2;
  localparam int unsigned HIST_DEPTH     = 8;
  localparam int unsigned HIST_AW        = $clog2(HIST_DEPTH);
  localparam int unsigned BW_SHIFT       = WORK_FRAC + 1;
  localparam int unsigned Y_SHIFT        = COEF_FRAC_BITS - WORK_FRAC;

  // volume: n / 100 as (n * DIV_K) >> DIV_S, then one correction step
  localparam logic [VOL_W-1:0] VOL_BYPASS = 7'd100;
  localparam int unsigned DIV_D  = 100;
  localparam int unsigned DIV_S  = 29;
  localparam logic signed [COEF_W-1:0] DIV_K = COEF_W'((64'd1 << DIV_S) / DIV_D);
  localparam int unsigned VOL_HALF = DIV_D / 2;
  localparam int unsigned Q_W    = 16;

  // register map
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned CFG_DW  = 32;
  localparam logic [2:0] REG_FILTER_EN = 3'd0;
  localparam logic [2:0] REG_SEC0_B    = 3'd1;
  localparam logic [2:0] REG_SEC0_A1   = 3'd2;
  localparam logic [2:0] REG_SEC0_A2   = 3'd3;
  localparam logic [2:0] REG_SEC1_B    = 3'd4;
  localparam logic [2:0] REG_SEC1_A1   = 3'd5;
  localparam logic [2:0] REG_SEC1_A2   = 3'd6;
  localparam logic [2:0] REG_VOLUME    = 3'd7;

  localparam logic signed [COEF_W-1:0] RST_SEC0_B  = 32'sd1802050498;
  localparam logic signed [COEF_W-1:0] RST_SEC0_A1 = 32'sd1784569606;
  localparam logic signed [COEF_W-1:0] RST_SEC0_A2 = 32'sd745789567;
  localparam logic signed [COEF_W-1:0] RST_SEC1_B  = 32'sd1979096900;
  localparam logic signed [COEF_W-1:0] RST_SEC1_A1 = 32'sd1959898557;
  localparam logic signed [COEF_W-1:0] RST_SEC1_A2 = 32'sd924553418;

  typedef struct packed {
    logic                           filter_en;
    logic signed [1:0][COEF_W-1:0]  b;
    logic signed [1:0][COEF_W-1:0]  a1;
    logic signed [1:0][COEF_W-1:0]  a2;
    logic [VOL_W-1:0]               vol;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SEL,
    OP_MB, OP_YF, OP_Y, OP_MA1, OP_D1, OP_Z0, OP_Z1, OP_FIN,
    OP_V1, OP_V2, OP_V3, OP_V4, OP_V5, OP_V6,
    OP_STORE, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
    logic   sec;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL,
    ST_MB, ST_YF, ST_Y, ST_MA1, ST_D1, ST_Z0, ST_Z1, ST_FIN,
    ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_V6,
    ST_STORE, ST_DONE
  } ctrl_state_t;

  // arithmetic shift right, rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] bias;
    half = 64'sd1 <<< (s - 1);
    bias = v[63] ? (half - 64'sd1) : half;
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [63:0] sat_bits(input logic signed [63:0] v,
                                                  input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

// ===== design/sbq_regs.sv =====
module sbq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbq_pkg::CFG_AW-1:0]  paddr,
  input  logic [sbq_pkg::CFG_DW-1:0]  pwdata,
  output logic [sbq_pkg::CFG_DW-1:0]  prdata,
  output sbq_pkg::cfg_t               cfg
);
  import sbq_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[CFG_AW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_en <= 1'b1;
      cfg_r.b[0]      <= RST_SEC0_B;
      cfg_r.a1[0]     <= RST_SEC0_A1;
      cfg_r.a2[0]     <= RST_SEC0_A2;
      cfg_r.b[1]      <= RST_SEC1_B;
      cfg_r.a1[1]     <= RST_SEC1_A1;
      cfg_r.a2[1]     <= RST_SEC1_A2;
      cfg_r.vol       <= VOL_BYPASS;
    end else if (wr_en) begin
      unique case (idx)
        REG_FILTER_EN: cfg_r.filter_en <= pwdata[0];
        REG_SEC0_B:    cfg_r.b[0]      <= pwdata;
        REG_SEC0_A1:   cfg_r.a1[0]     <= pwdata;
        REG_SEC0_A2:   cfg_r.a2[0]     <= pwdata;
        REG_SEC1_B:    cfg_r.b[1]      <= pwdata;
        REG_SEC1_A1:   cfg_r.a1[1]     <= pwdata;
        REG_SEC1_A2:   cfg_r.a2[1]     <= pwdata;
        REG_VOLUME:    cfg_r.vol       <= pwdata[VOL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILTER_EN: prdata = CFG_DW'(cfg_r.filter_en);
      REG_SEC0_B:    prdata = cfg_r.b[0];
      REG_SEC0_A1:   prdata = cfg_r.a1[0];
      REG_SEC0_A2:   prdata = cfg_r.a2[0];
      REG_SEC1_B:    prdata = cfg_r.b[1];
      REG_SEC1_A1:   prdata = cfg_r.a1[1];
      REG_SEC1_A2:   prdata = cfg_r.a2[1];
      REG_VOLUME:    prdata = CFG_DW'(cfg_r.vol);
    endcase
  end

endmodule

// ===== design/sbq_ctrl.sv =====
module sbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sbq_pkg::cfg_t     cfg,
  output sbq_pkg::dp_cmd_t  cmd
);
  import sbq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        ch_r, ch_nxt;
  logic        sec_r, sec_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        vol_act;
  logic        out_free;

  assign vol_act  = cfg.vol < VOL_BYPASS;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      sec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        ch_nxt = 1'b0;
        if (in_valid) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        sec_nxt = 1'b0;
        priority if (cfg.filter_en) state_nxt = ST_MB;
        else if (vol_act)           state_nxt = ST_V1;
        else                        state_nxt = ST_STORE;
      end
      ST_MB:  state_nxt = ST_YF;
      ST_YF:  state_nxt = ST_Y;
      ST_Y:   state_nxt = ST_MA1;
      ST_MA1: state_nxt = ST_D1;
      ST_D1:  state_nxt = ST_Z0;
      ST_Z0:  state_nxt = ST_Z1;
      ST_Z1: begin
        if (!sec_r) begin
          sec_nxt   = 1'b1;
          state_nxt = ST_MB;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = vol_act ? ST_V1 : ST_STORE;
      ST_V1:  state_nxt = ST_V2;
      ST_V2:  state_nxt = ST_V3;
      ST_V3:  state_nxt = ST_V4;
      ST_V4:  state_nxt = ST_V5;
      ST_V5:  state_nxt = ST_V6;
      ST_V6:  state_nxt = ST_STORE;
      ST_STORE: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ST_SEL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ch  = ch_r;
    cmd.sec = sec_r;
    unique case (state_r)
      ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_SEL:   cmd.op = OP_SEL;
      ST_MB:    cmd.op = OP_MB;
      ST_YF:    cmd.op = OP_YF;
      ST_Y:     cmd.op = OP_Y;
      ST_MA1:   cmd.op = OP_MA1;
      ST_D1:    cmd.op = OP_D1;
      ST_Z0:    cmd.op = OP_Z0;
      ST_Z1:    cmd.op = OP_Z1;
      ST_FIN:   cmd.op = OP_FIN;
      ST_V1:    cmd.op = OP_V1;
      ST_V2:    cmd.op = OP_V2;
      ST_V3:    cmd.op = OP_V3;
      ST_V4:    cmd.op = OP_V4;
      ST_V5:    cmd.op = OP_V5;
      ST_V6:    cmd.op = OP_V6;
      ST_STORE: cmd.op = OP_STORE;
      ST_DONE:  cmd.op = out_free ? OP_OUT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    priority if (state_r == ST_DONE && out_free) out_valid_nxt = 1'b1;
    else if (!out_stall)                         out_valid_nxt = 1'b0;
    else                                         out_valid_nxt = out_valid_r;
  end

endmodule

// ===== design/sbq_datapath.sv =====
module sbq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbq_pkg::cfg_t                       cfg,
  input  sbq_pkg::dp_cmd_t                    cmd,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0] in_right_in,
  output logic signed [sbq_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [sbq_pkg::SAMPLE_W-1:0] out_right_out
);
  import sbq_pkg::*;

  // captured inputs, per-channel results, output register
  logic signed [SAMPLE_W-1:0] in_l_r, in_r_r;
  logic signed [SAMPLE_W-1:0] res_l_r, res_r_r;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r;

  // working registers
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [PROD_W-1:0]   bw_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [WORK_W-1:0]   y_r, y_nxt;
  logic signed [SAMPLE_W-1:0] xs_r, xs_nxt;
  logic [Q_W-1:0]             q_r;
  logic                       neg_r;

  // history memory, cleared through valid bits
  logic signed [HIST_W-1:0]   hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]      vld_r;
  logic signed [HIST_W-1:0]   rd_data_r;
  logic                       rd_vld_r;
  logic                       hist_re, hist_we;
  logic [HIST_AW-1:0]         hist_addr;
  logic signed [HIST_W-1:0]   hist_wdata;
  logic signed [HIST_W-1:0]   z_rd;

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [WORK_W-1:0]   mul_b;
  logic signed [SAMPLE_W-1:0] sample;

  logic signed [63:0]         yf_full, y_full, z0_full, z1_full, fin_full;
  logic signed [PROD_W-1:0]   prod_abs;
  logic [ACC_W-1:0]           q_x100;
  logic [Q_W-1:0]             q_fix;

  assign sample    = cmd.ch ? in_r_r : in_l_r;
  assign z_rd      = rd_vld_r ? rd_data_r : '0;
  assign hist_re   = (cmd.op == OP_MB) || (cmd.op == OP_D1);
  assign hist_we   = (cmd.op == OP_Z0) || (cmd.op == OP_Z1);
  // entry = {channel, section, tap}; tap 1 read in D1, written in Z1
  assign hist_addr = {cmd.ch, cmd.sec, (cmd.op == OP_D1) || (cmd.op == OP_Z1)};
  assign hist_wdata = (cmd.op == OP_Z0) ? z0_full[HIST_W-1:0] : z1_full[HIST_W-1:0];

  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = cfg.b[cmd.sec];
    mul_b = y_r;
    unique case (cmd.op)
      OP_MA1: mul_a = cfg.a1[cmd.sec];
      OP_D1:  mul_a = cfg.a2[cmd.sec];
      OP_V1: begin
        mul_a = COEF_W'(cfg.vol);
        mul_b = WORK_W'(xs_r);
      end
      OP_V3: begin
        mul_a = DIV_K;
        mul_b = acc_r[WORK_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    yf_full  = rnd_shift(64'(prod_r), BW_SHIFT) + 64'(z_rd);
    y_full   = sat_bits(rnd_shift(64'(acc_r), Y_SHIFT), WORK_W);
    z0_full  = sat_bits(rnd_shift(64'(acc_r), WORK_FRAC) + 64'(z_rd), HIST_W);
    z1_full  = sat_bits(rnd_shift(64'(acc_r), BW_SHIFT), HIST_W);
    fin_full = sat_bits(rnd_shift(64'(y_r), WORK_FRAC), SAMPLE_W);
    prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;
    q_x100   = ACC_W'(q_r) * ACC_W'(DIV_D);
    q_fix    = q_r + Q_W'(acc_r >= ACC_W'(DIV_D));
  end

  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    y_nxt    = y_r;
    xs_nxt   = xs_r;
    unique case (cmd.op)
      OP_SEL: begin
        xs_nxt = sample;
        y_nxt  = WORK_W'(sample) <<< WORK_FRAC;
      end
      OP_MB, OP_MA1, OP_V1, OP_V3: prod_nxt = mul_a * mul_b;
      OP_YF:  acc_nxt = yf_full[ACC_W-1:0];
      OP_Y:   y_nxt   = y_full[WORK_W-1:0];
      OP_D1: begin
        acc_nxt  = ACC_W'(bw_r) - ACC_W'(prod_r);
        prod_nxt = mul_a * mul_b;
      end
      OP_Z0:  acc_nxt = ACC_W'(bw_r) - (ACC_W'(prod_r) <<< 1);
      OP_FIN: xs_nxt  = fin_full[SAMPLE_W-1:0];
      OP_V2:  acc_nxt = ACC_W'(prod_abs) + ACC_W'(VOL_HALF);
      OP_V5:  acc_nxt = acc_r - $signed(q_x100);
      OP_V6:  xs_nxt  = neg_r ? $signed(Q_W'(0) - q_fix) : $signed(q_fix);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    y_r    <= y_nxt;
    xs_r   <= xs_nxt;
    if (cmd.op == OP_YF) bw_r <= prod_r;
    if (cmd.op == OP_V2) neg_r <= prod_r[PROD_W-1];
    if (cmd.op == OP_V4) q_r <= prod_r[DIV_S+Q_W-1:DIV_S];
    if (cmd.op == OP_LOAD) begin
      in_l_r <= in_left_in;
      in_r_r <= in_right_in;
    end
    if (cmd.op == OP_STORE) begin
      if (cmd.ch) res_r_r <= xs_r;
      else        res_l_r <= xs_r;
    end
    if (cmd.op == OP_OUT) begin
      out_l_r <= res_l_r;
      out_r_r <= res_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_addr] <= hist_wdata;
    if (hist_re) rd_data_r <= hist_mem[hist_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (hist_we) vld_r[hist_addr] <= 1'b1;
      if (hist_re) rd_vld_r <= vld_r[hist_addr];
    end
  end

endmodule

// ===== design/stereo_biquad_lowpass_volume_unit.sv =====
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   in_left_in, in_right_in (s16)
// out       out  out_valid/out_stall out_left_out, out_right_out (s16)
// cfg       in   psel/penable/pready paddr[4:2] = register, pwdata/prdata 32b
//
// One item is worked on at a time (in_stall is high until the sequencer is idle);
// the pace is set by the one shared 32x26 multiplier and single-port history
// memory, one channel/section at a time.
// Reset (synchronous, rst_n low) restores register defaults; history reads zero
// until written. A finished item waits in the output register while the next
// item is taken, which then holds at its last step until out_stall drops.
module stereo_biquad_lowpass_volume_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0] in_right_in,
  // result item
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sbq_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [sbq_pkg::SAMPLE_W-1:0] out_right_out,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbq_pkg::CFG_AW-1:0]          paddr,
  input  logic [sbq_pkg::CFG_DW-1:0]          pwdata,
  output logic [sbq_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);
  import sbq_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // zero-wait register port
  assign pready = 1'b1;

  sbq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: per channel, select sample; if enabled, two biquad sections of
  // seven steps each and final rounding; if vol < 100, the divide-by-100 steps
  sbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg       (cfg),
    .cmd       (cmd)
  );

  // multiplier, accumulator, history memory and item registers
  sbq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

// ===== bench/stereo_biquad_lowpass_volume_unit_test.sv =====
`timescale 1ns / 100ps

// Bench for the stereo low-pass / volume unit.
// A table of directed frames and register writes runs first. Then come
// several random phases, each with its own coefficients, enable and volume.
// Every accepted frame goes through a local model of the two-section cascade
// and the volume stage, with its own history per channel and register copy.
// Results are checked in order against the model or a row's given answer.
module stereo_biquad_lowpass_volume_unit_test;
  import sbq_pkg::*;

  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int SETTLE_CYCLES   = 60;     // longer than the worst-case item time
  localparam int DRAIN_LIMIT     = 4000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 127;
  localparam int NUM_COEFS       = 6;
  localparam longint PERCENT     = 100;
  localparam longint PERCENT_HALF = 50;
  localparam longint I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN     = -I64_MAX - 64'sd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  typedef enum logic [1:0] {ROW_FRAME, ROW_KNOWN_FRAME, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [2:0]                 reg_idx;
    logic [CFG_DW-1:0]          value;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] want_left;
    logic signed [SAMPLE_W-1:0] want_right;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [CFG_AW-1:0]          paddr;
  logic [CFG_DW-1:0]          pwdata;
  logic [CFG_DW-1:0]          prdata;
  logic                       pready;

  // knobs for the driver (send_gaps) and the stall process (stall_on)
  bit send_gaps;
  bit stall_on;

  // a directed row may carry its answer; the checker takes it instead of the model's
  bit                         known_valid;
  logic signed [SAMPLE_W-1:0] known_left;
  logic signed [SAMPLE_W-1:0] known_right;

  // register image and filter history seen by the model
  bit         filt_on;
  int         coef_b  [2];
  int         coef_a1 [2];
  int         coef_a2 [2];
  logic [6:0] vol_level;
  longint     hist [HIST_DEPTH];

  frame_t    pending_frames[$];
  stim_row_t stim_rows[$];
  int        fail_count;
  int        cycles_run;

  stereo_biquad_lowpass_volume_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left),
    .in_right_in   (in_right),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left),
    .out_right_out (out_right),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // arithmetic shift, ties go away from zero
  function automatic longint round_shift(input longint v, input int unsigned s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clamp_bits(input longint v, input int unsigned bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint add_clamped(input longint a, input longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  // One transposed-DF2 section; numerator is b/2, b, b/2, so b*w is shared
  // and the halving lands in the extra bit of shift.
  function automatic longint lowpass_section(input longint w, input int ch, input int sec);
    longint b, a1, a2, bw, yf, y, n0, n1;
    int     base;
    b    = coef_b[sec];
    a1   = coef_a1[sec];
    a2   = coef_a2[sec];
    base = ch * 4 + sec * 2;
    bw   = b * w;
    yf   = add_clamped(round_shift(bw, WORK_FRAC + 1), hist[base]);
    y    = clamp_bits(round_shift(yf, COEF_FRAC_BITS - WORK_FRAC), WORK_W);
    n0   = clamp_bits(add_clamped(round_shift(bw - a1 * y, WORK_FRAC), hist[base + 1]),
                      HIST_W);
    n1   = clamp_bits(round_shift(bw - 2 * a2 * y, WORK_FRAC + 1), HIST_W);
    hist[base]     = n0;
    hist[base + 1] = n1;
    return y;
  endfunction

  // cascade (when enabled) then volume; history is left alone while bypassed
  function automatic logic signed [SAMPLE_W-1:0] shape_sample(
      input logic signed [SAMPLE_W-1:0] x_in, input int ch);
    longint x, w, prod, mag, quot;
    x = x_in;
    if (filt_on) begin
      w = x <<< WORK_FRAC;
      w = lowpass_section(w, ch, 0);
      w = lowpass_section(w, ch, 1);
      x = clamp_bits(round_shift(w, WORK_FRAC), SAMPLE_W);
    end
    // volume of 100 or above counts as bypass
    if (vol_level < VOL_BYPASS) begin
      prod = x * longint'(vol_level);
      mag  = (prod < 0) ? -prod : prod;
      quot = (mag + PERCENT_HALF) / PERCENT;
      x    = clamp_bits((prod < 0) ? -quot : quot, SAMPLE_W);
    end
    return x[SAMPLE_W-1:0];
  endfunction

  function automatic logic [CFG_DW-1:0] reg_image(input logic [2:0] idx);
    case (idx)
      REG_FILTER_EN: return {31'b0, filt_on};
      REG_SEC0_B:    return coef_b[0];
      REG_SEC0_A1:   return coef_a1[0];
      REG_SEC0_A2:   return coef_a2[0];
      REG_SEC1_B:    return coef_b[1];
      REG_SEC1_A1:   return coef_a1[1];
      REG_SEC1_A2:   return coef_a2[1];
      default:       return {25'b0, vol_level};
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] default_coef(input int k);
    case (k)
      0:       return RST_SEC0_B;
      1:       return RST_SEC0_A1;
      2:       return RST_SEC0_A2;
      3:       return RST_SEC1_B;
      4:       return RST_SEC1_A1;
      default: return RST_SEC1_A2;
    endcase
  endfunction

  // ------------------------------------------------------------- checking

  // Everything is looked at on the rising edge: register writes update the
  // image, accepted frames go through the model, results are compared.
  always @(posedge clk) begin : check_edge
    frame_t predicted;
    frame_t want;
    if (!rst_n) begin
      filt_on   = 1'b1;
      coef_b    = '{RST_SEC0_B, RST_SEC1_B};
      coef_a1   = '{RST_SEC0_A1, RST_SEC1_A1};
      coef_a2   = '{RST_SEC0_A2, RST_SEC1_A2};
      vol_level = VOL_BYPASS;
      foreach (hist[i]) hist[i] = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_FILTER_EN: filt_on    = pwdata[0];
            REG_SEC0_B:    coef_b[0]  = pwdata;
            REG_SEC0_A1:   coef_a1[0] = pwdata;
            REG_SEC0_A2:   coef_a2[0] = pwdata;
            REG_SEC1_B:    coef_b[1]  = pwdata;
            REG_SEC1_A1:   coef_a1[1] = pwdata;
            REG_SEC1_A2:   coef_a2[1] = pwdata;
            default:       vol_level  = pwdata[6:0];
          endcase
        end else if (prdata !== reg_image(paddr[4:2])) begin
          $error("prdata at register %0d: expected %h, got %h",
                 paddr[4:2], reg_image(paddr[4:2]), prdata);
          fail_count++;
        end
      end

      if (in_valid && !in_stall) begin
        // model always advances, even when the row supplies its own answer
        predicted.left  = shape_sample(in_left, 0);
        predicted.right = shape_sample(in_right, 1);
        want = known_valid ? frame_t'{known_left, known_right} : predicted;
        pending_frames.push_back(want);
      end

      if (out_valid && !out_stall) begin
        if (pending_frames.size() == 0) begin
          $error("result item with no frame pending: left %0d right %0d",
                 out_left, out_right);
          fail_count++;
        end else begin
          want = pending_frames.pop_front();
          if (out_left !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, out_left);
            fail_count++;
          end
          if (out_right !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, out_right);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("simulation failed");
    $finish;
  end

  // receiver backpressure: random bursts of out_stall while enabled
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- stimulus

  function automatic stim_row_t frame_row(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r);
    return '{ROW_FRAME, 3'd0, '0, l, r, '0, '0};
  endfunction

  function automatic stim_row_t known_row(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r,
                                          input logic signed [SAMPLE_W-1:0] wl,
                                          input logic signed [SAMPLE_W-1:0] wr);
    return '{ROW_KNOWN_FRAME, 3'd0, '0, l, r, wl, wr};
  endfunction

  function automatic stim_row_t write_row(input logic [2:0] idx,
                                          input logic [CFG_DW-1:0] val);
    return '{ROW_REG_WRITE, idx, val, '0, '0, '0, '0};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($signed($urandom_range(0, 600)) - 300);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high, so no toggle is needed, or after a send_gaps gap with it low.
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input bit has_answer,
                            input logic signed [SAMPLE_W-1:0] wl,
                            input logic signed [SAMPLE_W-1:0] wr);
    in_left     = l;
    in_right    = r;
    known_valid = has_answer;
    known_left  = wl;
    known_right = wr;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Hold off until every frame has come back, then let the pipe go quiet.
  task automatic drain(input int tail);
    int waited;
    waited   = 0;
    in_valid = 1'b0;
    while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_frames.size() != 0) begin
      $error("%0d result items never arrived", pending_frames.size());
      fail_count++;
      pending_frames.delete();
    end
    repeat (tail) @(negedge clk);
  endtask

  // two-phase register access; pready is waited for even though it is tied high
  task automatic reg_access(input bit wr, input logic [2:0] idx,
                            input logic [CFG_DW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    logic [CFG_DW-1:0] coef;
    logic [6:0]        vol_pick;
    bit                last_phase;

    in_valid    = 1'b0;
    in_left     = '0;
    in_right    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    known_valid = 1'b0;
    known_left  = '0;
    known_right = '0;
    fail_count  = 0;
    send_gaps   = 1'b1;
    stall_on    = 1'b1;
    rst_n       = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // --- directed table
    // reset state: filter on with the default coefficient set, zero history, volume bypass
    stim_rows.push_back(known_row(16'sd0, 16'sd0, 16'sd0, 16'sd0));
    stim_rows.push_back(frame_row(16'sh7FFF, 16'sh8000));
    stim_rows.push_back(frame_row(16'sh8000, 16'sh7FFF));
    stim_rows.push_back(frame_row(16'sd12345, -16'sd1));
    stim_rows.push_back(frame_row(16'sd0, 16'sd0));
    stim_rows.push_back(frame_row(16'sd0, 16'sd0));
    // bypass: samples pass untouched, history is frozen
    stim_rows.push_back(write_row(REG_FILTER_EN, 32'd0));
    stim_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
    stim_rows.push_back(known_row(-16'sd1, 16'sd1, -16'sd1, 16'sd1));
    // volume corners; ties at .5 round away from zero
    stim_rows.push_back(write_row(REG_VOLUME, 32'd0));
    stim_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0));
    stim_rows.push_back(write_row(REG_VOLUME, 32'd50));
    stim_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd16384, -16'sd16384));
    stim_rows.push_back(write_row(REG_VOLUME, 32'd1));
    stim_rows.push_back(known_row(16'sd50, -16'sd50, 16'sd1, -16'sd1));
    stim_rows.push_back(known_row(16'sd49, -16'sd49, 16'sd0, 16'sd0));
    stim_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sd328, -16'sd328));
    // upper data bits are dropped: 0xFF leaves 127, which is above 100 -> bypass
    stim_rows.push_back(write_row(REG_VOLUME, 32'h0000_00FF));
    stim_rows.push_back(known_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
    // filter back on: picks up the held history
    stim_rows.push_back(write_row(REG_FILTER_EN, 32'd1));
    stim_rows.push_back(frame_row(16'sd1000, -16'sd1000));
    stim_rows.push_back(frame_row(16'sd0, 16'sd0));
    stim_rows.push_back(write_row(REG_VOLUME, 32'd99));
    stim_rows.push_back(frame_row(16'sd20000, -16'sd20000));
    // coefficient extremes: every intermediate should saturate, never wrap
    stim_rows.push_back(write_row(REG_SEC0_B,  32'h7FFF_FFFF));
    stim_rows.push_back(write_row(REG_SEC0_A1, 32'h8000_0000));
    stim_rows.push_back(write_row(REG_SEC0_A2, 32'h7FFF_FFFF));
    stim_rows.push_back(write_row(REG_SEC1_B,  32'h8000_0000));
    stim_rows.push_back(write_row(REG_SEC1_A1, 32'h7FFF_FFFF));
    stim_rows.push_back(write_row(REG_SEC1_A2, 32'h8000_0000));
    stim_rows.push_back(write_row(REG_VOLUME, 32'd100));
    stim_rows.push_back(frame_row(16'sh7FFF, 16'sh8000));
    stim_rows.push_back(frame_row(16'sh8000, 16'sh7FFF));
    stim_rows.push_back(frame_row(16'sh7FFF, 16'sh7FFF));
    stim_rows.push_back(frame_row(16'sh8000, 16'sh8000));
    // zero coefficients: output comes from the saturated history alone
    for (int k = 0; k < NUM_COEFS; k++)
      stim_rows.push_back(write_row(3'(REG_SEC0_B + k), 32'd0));
    stim_rows.push_back(frame_row(16'sh7FFF, 16'sh8000));
    stim_rows.push_back(frame_row(16'sd0, 16'sd0));

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_REG_WRITE: begin
          drain(SETTLE_CYCLES);
          reg_access(1'b1, stim_rows[i].reg_idx, stim_rows[i].value);
        end
        ROW_KNOWN_FRAME: send_frame(stim_rows[i].left, stim_rows[i].right, 1'b1,
                                    stim_rows[i].want_left, stim_rows[i].want_right);
        default: send_frame(stim_rows[i].left, stim_rows[i].right, 1'b0, '0, '0);
      endcase
    end

    // --- random phases; the final one runs with no idling at all
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      last_phase = (phase == NUM_PHASES - 1);
      drain(SETTLE_CYCLES);

      reg_access(1'b1, REG_FILTER_EN, last_phase ? 32'd1 : 32'($urandom_range(0, 3) != 0));
      for (int k = 0; k < NUM_COEFS; k++) begin
        case (last_phase ? 0 : $urandom_range(0, 5))
          0, 1, 2: coef = default_coef(k);
          3:       coef = default_coef(k) + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
          4:       coef = $urandom;
          default: begin
            case ($urandom_range(0, 4))
              0:       coef = 32'h7FFF_FFFF;
              1:       coef = 32'h8000_0000;
              2:       coef = 32'h0000_0000;
              3:       coef = 32'h0000_0001;
              default: coef = 32'hFFFF_FFFF;
            endcase
          end
        endcase
        reg_access(1'b1, 3'(REG_SEC0_B + k), coef);
      end
      case ($urandom_range(0, 7))
        0:       vol_pick = 7'd0;
        1:       vol_pick = 7'd1;
        2:       vol_pick = 7'd99;
        3:       vol_pick = VOL_BYPASS;
        4:       vol_pick = 7'd101;
        5:       vol_pick = 7'd127;
        default: vol_pick = 7'($urandom_range(0, 127));
      endcase
      reg_access(1'b1, REG_VOLUME, {25'b0, vol_pick});
      for (int r = 0; r < 8; r++)
        reg_access(1'b0, 3'(r), '0);

      case (last_phase ? 3 : $urandom_range(0, 3))
        0:       begin send_gaps = 1'b1; stall_on = 1'b1; end
        1:       begin send_gaps = 1'b1; stall_on = 1'b0; end
        2:       begin send_gaps = 1'b0; stall_on = 1'b1; end
        default: begin send_gaps = 1'b0; stall_on = 1'b0; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
    end

    drain(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
